// ===== hw/rtl/cotts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cotts_pkg
// Shared types and constants of the cooperative task table scheduler.
// ----------------------------------------------------------------------------
package cotts_pkg;

	localparam int TASKS_DEF   = 8;
	localparam int MAX_RESULTS = 8;
	localparam int RUN_CNT_W   = 3;
	localparam int HANDLE_W    = 8;
	localparam int TIME_W      = 16;
	localparam int PEND_W      = 8;
	localparam int SLOT_W      = 3;
	localparam int MODE_W      = 2;

	localparam logic [PEND_W-1:0]    PEND_MAX  = {PEND_W{1'b1}};
	localparam logic [RUN_CNT_W-1:0] RUN_FINAL = RUN_CNT_W'(MAX_RESULTS - 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD  = 2'd0,
		MODE_DEL  = 2'd1,
		MODE_TICK = 2'd2,
		MODE_DISP = 2'd3
	} mode_t;

	// one table slot as held in the task memory
	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   delay;
		logic [TIME_W-1:0]   reload;
		logic [TIME_W-1:0]   period;
		logic [PEND_W-1:0]   pending;
	} row_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic del;
		logic tick_rd;
		logic disp_rd;
		logic disp_commit;
		logic add_commit;
		logic disp_final;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic nz_here;
		logic disp_last;
	} stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cotts_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cotts_ctrl
// Sequencer: takes requests, walks the slots for tick and dispatch passes.
// ----------------------------------------------------------------------------
module cotts_ctrl import cotts_pkg::*; #(
	parameter int TASKS = TASKS_DEF,
	localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1,
	localparam int CNT_W = $clog2(TASKS + 1)
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [MODE_W-1:0] mode,
	input  stat_t             stat,
	output cmd_t              cmd,
	output logic [IDX_W-1:0]  scan_addr
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ADD   = 5'b00010,
		ST_TICK  = 5'b00100,
		ST_DSCAN = 5'b01000,
		ST_DEMIT = 5'b10000
	} state_t;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [RUN_CNT_W-1:0] runs_q, runs_d;
	logic                 scan_end;

	assign scan_addr = cnt_q[IDX_W-1:0];
	assign scan_end  = (cnt_q == CNT_W'(TASKS));

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		runs_d   = runs_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					cnt_d       = '0;
					runs_d      = '0;
					case (mode_t'(mode))
						MODE_ADD:  state_d = ST_ADD;
						MODE_DEL:  cmd.del = 1'b1;
						MODE_TICK: state_d = ST_TICK;
						MODE_DISP: state_d = ST_DSCAN;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				if (stat.out_free) begin
					cmd.add_commit = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_TICK: begin
				// reads run one slot ahead of the write-back stage
				if (scan_end) begin
					state_d = ST_IDLE;
				end else begin
					cmd.tick_rd = 1'b1;
					cnt_d       = cnt_q + 1'b1;
				end
			end
			ST_DSCAN: begin
				if (scan_end) begin
					state_d = ST_IDLE;
				end else if (stat.nz_here) begin
					cmd.disp_rd = 1'b1;
					state_d     = ST_DEMIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DEMIT: begin
				cmd.disp_final = (runs_q == RUN_FINAL);
				if (stat.out_free) begin
					cmd.disp_commit = 1'b1;
					if (stat.disp_last) begin
						state_d = ST_IDLE;
					end else begin
						cnt_d   = cnt_q + 1'b1;
						runs_d  = runs_q + 1'b1;
						state_d = ST_DSCAN;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			runs_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			runs_q  <= runs_d;
		end
	end

	// the eighth run order of a pass always closes it
	a_final_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEMIT && stat.out_free && runs_q == RUN_FINAL) |=> state_q == ST_IDLE)
		else $error("dispatch pass kept going after its final run order");

	// a scan never reads past the last slot
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tick_rd || cmd.disp_rd) |-> (cnt_q < CNT_W'(TASKS)))
		else $error("slot read beyond the table");

	// a pass always starts at slot zero
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> (cnt_q == '0 && runs_q == '0))
		else $error("pass did not start at slot zero");

endmodule
`default_nettype wire

// ===== hw/rtl/cotts_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cotts_dp
// Task table memory, valid and pending flags, slot update and output register.
// ----------------------------------------------------------------------------
module cotts_dp import cotts_pkg::*; #(
	parameter int TASKS = TASKS_DEF,
	localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  cmd_t                cmd,
	input  wire  [IDX_W-1:0]    scan_addr,
	output stat_t               stat,
	input  wire  [HANDLE_W-1:0] task_handle,
	input  wire  [TIME_W-1:0]   start_delay,
	input  wire  [TIME_W-1:0]   period_value,
	input  wire  [TIME_W-1:0]   repeat_value,
	input  wire  [SLOT_W-1:0]   slot_select,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [SLOT_W-1:0]   slot_index,
	output logic [HANDLE_W-1:0] run_handle,
	output logic                run_valid,
	output logic                retired,
	output logic                table_full,
	output logic                last_result
);

	row_t             mem_q [TASKS];
	row_t             rd_row_q;
	row_t             add_row_q;
	row_t             tick_row, disp_row, wr_row;
	logic [IDX_W-1:0] wr_addr;
	logic             wr_en;

	logic [TASKS-1:0] valid_q, nz_q;
	logic             tick_s1;
	logic [IDX_W-1:0] slot_s1;

	logic [IDX_W-1:0] free_idx;
	logic             free_found;
	logic             nz_above;
	logic             disp_retire;
	logic [6:0]       free_ext, scan_ext;

	logic             out_free;
	logic             out_load;

	// request payload held for the add commit
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			add_row_q.handle  <= task_handle;
			add_row_q.delay   <= start_delay;
			add_row_q.period  <= period_value;
			add_row_q.reload  <= repeat_value;
			add_row_q.pending <= '0;
		end
	end

	// lowest free slot
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = TASKS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx   = IDX_W'(i);
				free_found = 1'b1;
			end
		end
	end

	// any pending slot after the current one
	always_comb begin
		nz_above = 1'b0;
		for (int i = 0; i < TASKS; i++) begin
			if (nz_q[i] && (IDX_W'(i) > scan_addr)) begin
				nz_above = 1'b1;
			end
		end
	end

	// tick update of one slot
	always_comb begin
		tick_row = rd_row_q;
		if (rd_row_q.delay == '0) begin
			if (rd_row_q.pending != PEND_MAX) begin
				tick_row.pending = rd_row_q.pending + 1'b1;
			end
			if (rd_row_q.reload != '0) begin
				tick_row.delay = rd_row_q.reload;
			end
		end else begin
			tick_row.delay = rd_row_q.delay - 1'b1;
		end
	end

	always_comb begin
		disp_row         = rd_row_q;
		disp_row.pending = rd_row_q.pending - 1'b1;
		disp_retire      = (rd_row_q.period == '0);
	end

	// single write port, the three writers never overlap
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = scan_addr;
		wr_row  = disp_row;
		if (cmd.add_commit) begin
			wr_en   = free_found;
			wr_addr = free_idx;
			wr_row  = add_row_q;
		end else if (tick_s1) begin
			wr_en   = 1'b1;
			wr_addr = slot_s1;
			wr_row  = tick_row;
		end else if (cmd.disp_commit) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		if (cmd.tick_rd || cmd.disp_rd) begin
			rd_row_q <= mem_q[scan_addr];
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= scan_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s1 <= 1'b0;
		end else begin
			tick_s1 <= cmd.tick_rd && valid_q[scan_addr];
		end
	end

	// slot flags; an invalid slot's memory row may be read but is never used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			nz_q    <= '0;
		end else begin
			for (int i = 0; i < TASKS; i++) begin
				if (cmd.del && (int'(slot_select) == i)) begin
					valid_q[i] <= 1'b0;
					nz_q[i]    <= 1'b0;
				end
				if (cmd.add_commit && free_found && (free_idx == IDX_W'(i))) begin
					valid_q[i] <= 1'b1;
					nz_q[i]    <= 1'b0;
				end
				if (tick_s1 && (slot_s1 == IDX_W'(i))) begin
					nz_q[i] <= (tick_row.pending != '0);
				end
				if (cmd.disp_commit && (scan_addr == IDX_W'(i))) begin
					nz_q[i] <= !disp_retire && (disp_row.pending != '0);
					if (disp_retire) begin
						valid_q[i] <= 1'b0;
					end
				end
			end
		end
	end

	assign out_free = !out_valid || out_ready;
	assign out_load = cmd.add_commit || cmd.disp_commit;
	assign free_ext = 7'(free_idx);
	assign scan_ext = 7'(scan_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_commit) begin
			slot_index  <= free_found ? free_ext[SLOT_W-1:0] : '0;
			run_handle  <= '0;
			run_valid   <= 1'b0;
			retired     <= 1'b0;
			table_full  <= !free_found;
			last_result <= 1'b1;
		end else if (cmd.disp_commit) begin
			slot_index  <= scan_ext[SLOT_W-1:0];
			run_handle  <= rd_row_q.handle;
			run_valid   <= 1'b1;
			retired     <= disp_retire;
			table_full  <= 1'b0;
			last_result <= stat.disp_last;
		end
	end

	assign stat.out_free  = out_free;
	assign stat.nz_here   = nz_q[scan_addr];
	assign stat.disp_last = cmd.disp_final || !nz_above;

	// pending runs only ever sit on occupied slots
	a_nz_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(nz_q & ~valid_q) == '0)
		else $error("pending runs on an empty slot");

	// table writers never collide
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.add_commit, tick_s1, cmd.disp_commit}))
		else $error("two writers on the task memory");

	// a result never overwrites one still waiting
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register loaded while occupied");

	// a run order always names a slot that had pending runs
	a_disp_nz: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.disp_commit |-> nz_q[scan_addr])
		else $error("run order for a slot with nothing pending");

endmodule
`default_nettype wire

// ===== hw/rtl/cooperative_task_table_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cooperative_task_table_scheduler
// Time-triggered task table: add, delete, timer tick and dispatch pass.
// ----------------------------------------------------------------------------
// One request is handled at a time; a finished result waits in the output
// register. Delete gives no result. Add gives one result (slot used, or
// table_full). Tick walks every slot through the task memory, reading one
// slot and writing back the one before it, one slot a cycle, and gives no
// result. Dispatch walks the slots too, passing over slots with nothing
// pending and issuing one run order per pending slot, ending after the last
// pending slot or the eighth run order; a run order waits while the output
// register is occupied. No clearing pass is needed after reset.
module cooperative_task_table_scheduler import cotts_pkg::*; #(
	parameter int TASKS = TASKS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [MODE_W-1:0]   mode,
	input  wire  [HANDLE_W-1:0] task_handle,
	input  wire  [TIME_W-1:0]   start_delay,
	input  wire  [TIME_W-1:0]   period_value,
	input  wire  [TIME_W-1:0]   repeat_value,
	input  wire  [SLOT_W-1:0]   slot_select,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [SLOT_W-1:0]   slot_index,
	output logic [HANDLE_W-1:0] run_handle,
	output logic                run_valid,
	output logic                retired,
	output logic                table_full,
	output logic                last_result
);

	localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

	cmd_t             cmd;
	stat_t            stat;
	logic [IDX_W-1:0] scan_addr;

	cotts_ctrl #(
		.TASKS(TASKS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.stat     (stat),
		.cmd      (cmd),
		.scan_addr(scan_addr)
	);

	cotts_dp #(
		.TASKS(TASKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.scan_addr   (scan_addr),
		.stat        (stat),
		.task_handle (task_handle),
		.start_delay (start_delay),
		.period_value(period_value),
		.repeat_value(repeat_value),
		.slot_select (slot_select),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.slot_index  (slot_index),
		.run_handle  (run_handle),
		.run_valid   (run_valid),
		.retired     (retired),
		.table_full  (table_full),
		.last_result (last_result)
	);

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the cooperative task table scheduler: add, delete, tick and dispatch
// requests go in under random pacing and output stalls, a table model in this
// file predicts every result, and a monitor compares each one field by field.
// ----------------------------------------------------------------------------
module testbench;
	import cotts_pkg::*;

	localparam int TASKS       = TASKS_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_WAIT  = 40;

	localparam int SINK_OPEN    = 0;
	localparam int SINK_RANDOM  = 1;
	localparam int SINK_PATTERN = 2;

	typedef struct {
		mode_t               mode;
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   delay;
		logic [TIME_W-1:0]   period;
		logic [TIME_W-1:0]   rpt;
		logic [SLOT_W-1:0]   slot;
	} request_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [HANDLE_W-1:0] handle;
		logic                run;
		logic                ret;
		logic                full;
		logic                last;
	} report_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	mode_t               mode = MODE_TICK;
	logic [HANDLE_W-1:0] task_handle = '0;
	logic [TIME_W-1:0]   start_delay = '0;
	logic [TIME_W-1:0]   period_value = '0;
	logic [TIME_W-1:0]   repeat_value = '0;
	logic [SLOT_W-1:0]   slot_select = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SLOT_W-1:0]   slot_index;
	logic [HANDLE_W-1:0] run_handle;
	logic                run_valid;
	logic                retired;
	logic                table_full;
	logic                last_result;

	// task table as the scheduler should hold it
	logic                tbl_valid [TASKS];
	logic [HANDLE_W-1:0] tbl_handle [TASKS];
	logic [TIME_W-1:0]   tbl_delay [TASKS];
	logic [TIME_W-1:0]   tbl_reload [TASKS];
	logic [TIME_W-1:0]   tbl_period [TASKS];
	logic [PEND_W-1:0]   tbl_pend [TASKS];

	report_t slot_reports [$];
	report_t head_report;

	int errors = 0;
	int cycles = 0;
	int n_requests = 0;
	int n_adds = 0;
	int n_full = 0;
	int n_ticks = 0;
	int n_runs = 0;
	int n_retired = 0;
	int n_saturated = 0;
	int widest_pass = 0;

	int sink_style = SINK_OPEN;
	int sink_cycle = 0;
	int hold_len = 0;
	int hold_left = 0;

	cooperative_task_table_scheduler #(.TASKS(TASKS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.task_handle(task_handle),
		.start_delay(start_delay),
		.period_value(period_value),
		.repeat_value(repeat_value),
		.slot_select(slot_select),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slot_index(slot_index),
		.run_handle(run_handle),
		.run_valid(run_valid),
		.retired(retired),
		.table_full(table_full),
		.last_result(last_result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				slot_reports.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// output side: long hold-off on request, otherwise the current stall style
	always @(posedge clk) begin
		sink_cycle++;
		if (hold_len > 0) begin
			hold_left = hold_len;
			hold_len = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (sink_style)
				SINK_OPEN: out_ready <= 1'b1;
				SINK_RANDOM: out_ready <= ($urandom_range(0, 99) >= 35);
				default: out_ready <= (sink_cycle % 7 != 2) && (sink_cycle % 7 != 5);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (slot_reports.size() == 0) begin
				$error("unexpected result: slot_index %0d run_handle %0d", slot_index, run_handle);
				errors++;
			end else begin
				head_report = slot_reports.pop_front();
				if (slot_index !== head_report.slot) begin
					$error("slot_index expected %0d actual %0d", head_report.slot, slot_index);
					errors++;
				end
				if (run_handle !== head_report.handle) begin
					$error("run_handle expected %0d actual %0d", head_report.handle, run_handle);
					errors++;
				end
				if (run_valid !== head_report.run) begin
					$error("run_valid expected %0b actual %0b", head_report.run, run_valid);
					errors++;
				end
				if (retired !== head_report.ret) begin
					$error("retired expected %0b actual %0b", head_report.ret, retired);
					errors++;
				end
				if (table_full !== head_report.full) begin
					$error("table_full expected %0b actual %0b", head_report.full, table_full);
					errors++;
				end
				if (last_result !== head_report.last) begin
					$error("last_result expected %0b actual %0b", head_report.last, last_result);
					errors++;
				end
			end
		end
	end

	function automatic report_t make_report(int s, logic [HANDLE_W-1:0] h, logic run,
			logic ret, logic full);
		report_t rep;
		rep.slot = s[SLOT_W-1:0];
		rep.handle = h;
		rep.run = run;
		rep.ret = ret;
		rep.full = full;
		rep.last = 1'b0;
		return rep;
	endfunction

	task automatic clear_table();
		for (int s = 0; s < TASKS; s++) begin
			tbl_valid[s] = 1'b0;
			tbl_handle[s] = '0;
			tbl_delay[s] = '0;
			tbl_reload[s] = '0;
			tbl_period[s] = '0;
			tbl_pend[s] = '0;
		end
	endtask

	// applies one accepted request to the table and queues the results it causes
	task automatic step_task_table(input request_t r);
		report_t batch [$];
		report_t rep;
		int s;
		s = 0;
		case (r.mode)
			MODE_ADD: begin
				n_adds++;
				while (s < TASKS && tbl_valid[s])
					s++;
				if (s >= TASKS) begin
					n_full++;
					rep = make_report(0, '0, 1'b0, 1'b0, 1'b1);
				end else begin
					tbl_valid[s] = 1'b1;
					tbl_handle[s] = r.handle;
					tbl_delay[s] = r.delay;
					tbl_period[s] = r.period;
					tbl_reload[s] = r.rpt;
					tbl_pend[s] = '0;
					rep = make_report(s, '0, 1'b0, 1'b0, 1'b0);
				end
				rep.last = 1'b1;
				slot_reports.push_back(rep);
			end
			MODE_DEL: begin
				if (r.slot < TASKS) begin
					tbl_valid[r.slot] = 1'b0;
					tbl_delay[r.slot] = '0;
					tbl_period[r.slot] = '0;
					tbl_pend[r.slot] = '0;
				end
			end
			MODE_TICK: begin
				n_ticks++;
				for (s = 0; s < TASKS; s++) begin
					if (tbl_valid[s]) begin
						if (tbl_delay[s] == '0) begin
							if (tbl_pend[s] != PEND_MAX)
								tbl_pend[s] = tbl_pend[s] + 1'b1;
							else
								n_saturated++;
							if (tbl_reload[s] != '0)
								tbl_delay[s] = tbl_reload[s];
						end else begin
							tbl_delay[s] = tbl_delay[s] - 1'b1;
						end
					end
				end
			end
			default: begin
				for (s = 0; s < TASKS && batch.size() < MAX_RESULTS; s++) begin
					if (tbl_pend[s] != '0) begin
						tbl_pend[s] = tbl_pend[s] - 1'b1;
						rep = make_report(s, tbl_handle[s], 1'b1, tbl_period[s] == '0, 1'b0);
						batch.push_back(rep);
						if (rep.ret) begin
							n_retired++;
							tbl_valid[s] = 1'b0;
							tbl_delay[s] = '0;
							tbl_period[s] = '0;
							tbl_pend[s] = '0;
						end
					end
				end
				if (batch.size() > 0) begin
					batch[batch.size() - 1].last = 1'b1;
					n_runs += batch.size();
					if (batch.size() > widest_pass)
						widest_pass = batch.size();
				end
				foreach (batch[i])
					slot_reports.push_back(batch[i]);
			end
		endcase
	endtask

	// valid stays high after acceptance; the caller lowers it only for a gap
	task automatic send_request(input request_t r);
		in_valid <= 1'b1;
		mode <= r.mode;
		task_handle <= r.handle;
		start_delay <= r.delay;
		period_value <= r.period;
		repeat_value <= r.rpt;
		slot_select <= r.slot;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_requests++;
		step_task_table(r);
	endtask

	task automatic idle_sender(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (slot_reports.size() != 0)
			@(posedge clk);
	endtask

	function automatic request_t noise_request(mode_t m);
		request_t r;
		r.mode = m;
		r.handle = HANDLE_W'($urandom);
		r.delay = TIME_W'($urandom);
		r.period = TIME_W'($urandom);
		r.rpt = TIME_W'($urandom);
		r.slot = SLOT_W'($urandom);
		return r;
	endfunction

	function automatic request_t add_request(int h, int d, int p, int rp);
		request_t r;
		r = noise_request(MODE_ADD);
		r.handle = HANDLE_W'(h);
		r.delay = TIME_W'(d);
		r.period = TIME_W'(p);
		r.rpt = TIME_W'(rp);
		return r;
	endfunction

	function automatic request_t del_request(int s);
		request_t r;
		r = noise_request(MODE_DEL);
		r.slot = SLOT_W'(s);
		return r;
	endfunction

	// adds mostly get short delays and reloads so that tasks actually fall due
	function automatic request_t random_request();
		request_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			r = noise_request(MODE_ADD);
			pick = $urandom_range(0, 9);
			r.delay = TIME_W'((pick < 7) ? $urandom_range(0, 4) :
				(pick < 9) ? $urandom_range(0, 40) : $urandom);
			pick = $urandom_range(0, 9);
			r.period = TIME_W'((pick < 4) ? 0 : (pick < 8) ? $urandom_range(1, 3) : $urandom);
			pick = $urandom_range(0, 9);
			r.rpt = TIME_W'((pick < 4) ? 0 : (pick < 8) ? $urandom_range(1, 4) : $urandom);
		end else if (pick < 32) begin
			r = noise_request(MODE_DEL);
		end else if (pick < 72) begin
			r = noise_request(MODE_TICK);
		end else begin
			r = noise_request(MODE_DISP);
		end
		return r;
	endfunction

	task automatic empty_table();
		for (int s = 0; s < TASKS; s++)
			send_request(del_request(s));
	endtask

	task automatic test_directed();
		sink_style = SINK_OPEN;
		send_request(noise_request(MODE_DISP));
		send_request(noise_request(MODE_TICK));
		send_request(add_request(0, 0, 0, 0));
		send_request(add_request(255, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_request(add_request(8'hA5, 1, 1, 2));
		send_request(noise_request(MODE_TICK));
		send_request(noise_request(MODE_TICK));
		// one-shot slot retires, periodic slot stays
		send_request(noise_request(MODE_DISP));
		for (int i = 0; i < 6; i++)
			send_request(add_request(8'h10 + i, 0, i, 0));
		// table full: no slot changes
		send_request(add_request(8'h77, 0, 0, 0));
		send_request(noise_request(MODE_TICK));
		send_request(noise_request(MODE_DISP));
		send_request(del_request(7));
		send_request(del_request(0));
		send_request(del_request(1));
		wait_drained();
	endtask

	task automatic test_run_count_saturation();
		sink_style = SINK_PATTERN;
		empty_table();
		send_request(add_request(8'h3C, 0, 3, 0));
		repeat (258) send_request(noise_request(MODE_TICK));
		repeat (3) send_request(noise_request(MODE_DISP));
		send_request(del_request(0));
		wait_drained();
	endtask

	// output held off while the sender keeps offering requests
	task automatic test_backpressure();
		sink_style = SINK_RANDOM;
		empty_table();
		hold_len = 200;
		for (int i = 0; i < TASKS; i++)
			send_request(add_request($urandom, 0, (i % 3 == 0) ? 0 : i, $urandom_range(0, 1)));
		send_request(add_request(8'hEE, 0, 0, 0));
		repeat (2) send_request(noise_request(MODE_TICK));
		repeat (3) send_request(noise_request(MODE_DISP));
		wait_drained();
	endtask

	task automatic test_random_mix(input int count);
		int burst_left;
		bit gaps_on;
		burst_left = 0;
		gaps_on = 1'b1;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				sink_style = $urandom_range(SINK_OPEN, SINK_PATTERN);
			if (i % 80 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			if (i == count / 2)
				wait_drained();
			send_request(random_request());
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				if (gaps_on)
					idle_sender($urandom_range(1, 20));
			end else begin
				burst_left--;
			end
		end
		wait_drained();
	endtask

	initial begin
		clear_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_run_count_saturation();
		test_backpressure();
		test_random_mix(320);
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("%0d requests: %0d adds (%0d on a full table), %0d ticks, %0d saturated counts",
			n_requests, n_adds, n_full, n_ticks, n_saturated);
		$display("%0d run orders, %0d one-shot retirements, widest dispatch pass %0d",
			n_runs, n_retired, widest_pass);
		if (errors == 0 && slot_reports.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, slot_reports.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/cotts_pkg.sv
hw/rtl/cotts_ctrl.sv
hw/rtl/cotts_dp.sv
hw/rtl/cooperative_task_table_scheduler.sv
verif/testbench.sv
